>>> hw/rtl/rpf_pkg.sv
// shared types, codes and the crc step of the radio packet framer
package rpf_pkg;

    // input commands
    localparam logic [2:0] CMD_LISTEN   = 3'd0;
    localparam logic [2:0] CMD_RX_BYTE  = 3'd1;
    localparam logic [2:0] CMD_TX_SPACE = 3'd2;
    localparam logic [2:0] CMD_SENT     = 3'd3;
    localparam logic [2:0] CMD_LOAD     = 3'd4;
    localparam logic [2:0] CMD_START    = 3'd5;
    localparam logic [2:0] CMD_CAN_SEND = 3'd6;
    localparam logic [2:0] CMD_READ     = 3'd7;

    // framer phases
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_RECV = 3'd1;
    localparam logic [2:0] PH_DATA = 3'd2;
    localparam logic [2:0] PH_CRC1 = 3'd3;
    localparam logic [2:0] PH_CRC2 = 3'd4;
    localparam logic [2:0] PH_TAIL = 3'd5;
    localparam logic [2:0] PH_DONE = 3'd6;

    // requested radio modes
    localparam logic [1:0] MODE_STANDBY  = 2'd0;
    localparam logic [1:0] MODE_RECEIVER = 2'd1;
    localparam logic [1:0] MODE_TRANSMIT = 2'd2;

    // register indexes
    localparam logic REG_NODE_ID  = 1'b0;
    localparam logic REG_GROUP_ID = 1'b1;

    localparam logic [15:0] CRC_SEED     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;
    localparam logic [7:0]  TAIL_BYTE    = 8'hAA;
    localparam logic [4:0]  BCAST_NODE   = 5'd31;
    localparam logic [7:0]  GROUP_RESET  = 8'd212;
    localparam logic [4:0]  NODE_RESET   = 5'd0;
    localparam logic [8:0]  HDR_OVERHEAD = 9'd5;
    // store entries 0..2 (group, header, length) live in flip-flops
    localparam int          REG_ENTRIES  = 3;

    // result transfer, radio_mode in the lowest bits
    typedef struct packed {
        logic       pad;
        logic       transmitting;
        logic [7:0] read_byte;
        logic       can_send;
        logic       crc_good;
        logic       packet_ready;
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic [1:0] radio_mode;
    } t_result;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/rpf_store.sv
// packet store memory with per-entry valid bits and write-to-read forwarding
module rpf_store #(
    parameter int DEPTH = 68,
    parameter int IDX_W = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_idx,
    input  logic [7:0]       i_wr_data,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_idx,
    output logic [7:0]       o_rd_data
);

    logic [7:0]       r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [7:0]       r_rd_data;
    logic             r_rd_vld;
    logic             r_fwd;
    logic [7:0]       r_fwd_data;
    logic             same_idx;

    assign same_idx = i_wr_en && (i_wr_idx == i_rd_idx);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_idx];
            r_fwd_data <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
            r_fwd    <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_idx] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_idx];
                r_fwd    <= same_idx;
            end
        end
    end

    // unwritten entries read as zero
    assign o_rd_data = r_fwd ? r_fwd_data : (r_rd_vld ? r_rd_data : 8'h00);

endmodule

>>> hw/rtl/rpf_core.sv
// framer state, command decode, store access and output register
module rpf_core #(
    parameter int MAX_DATA = 66
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [4:0]            i_node_id,
    input  logic [7:0]            i_group_id,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [31:0]           i_s_tdata,
    input  logic [2:0]            i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output rpf_pkg::t_result      o_m_result
);

    localparam int STORE  = MAX_DATA + 5;
    localparam int FILL_W = $clog2(STORE + 1);
    localparam int MEM_D  = STORE - rpf_pkg::REG_ENTRIES;
    localparam int MEM_W  = $clog2(MEM_D);
    localparam int AW     = (FILL_W > 7) ? FILL_W : 7;

    // s1 item
    logic              r_s1v;
    logic [2:0]        r_cmd;
    logic [7:0]        r_db;
    logic [7:0]        r_hdr_in;
    logic [7:0]        r_len_in;
    logic [6:0]        r_idx;
    // framer state
    logic [2:0]        r_phase, n_phase;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [15:0]       r_crc, n_crc;
    logic [7:0]        r_b0, n_b0;
    logic [7:0]        r_b1, n_b1;
    logic [7:0]        r_b2, n_b2;
    // output register
    logic              r_ovalid;
    rpf_pkg::t_result  r_odata, n_res;

    logic              out_free, s1_fire, accept;
    logic              wr_en;
    logic [MEM_W-1:0]  wr_idx;
    logic [7:0]        wr_data;
    logic [7:0]        mem_byte;
    logic [AW-1:0]     s1_addr, in_addr;
    logic [7:0]        s1_byte;
    logic [FILL_W-1:0] fill_eff;
    logic              in_mem;
    logic [MEM_W-1:0]  rd_idx;
    logic [7:0]        slen;

    assign out_free   = !r_ovalid || i_m_tready;
    assign s1_fire    = r_s1v && out_free;
    assign o_s_tready = !r_s1v || out_free;
    assign accept     = i_s_tvalid && o_s_tready;

    // store read issued with the transfer, using the state the item will see
    assign fill_eff = s1_fire ? n_fill : r_fill;
    assign in_addr  = (i_s_tuser == rpf_pkg::CMD_READ) ? AW'(i_s_tdata[30:24]) : AW'(fill_eff);
    assign in_mem   = (in_addr >= AW'(rpf_pkg::REG_ENTRIES)) && (in_addr < AW'(STORE));
    assign rd_idx   = in_mem ? MEM_W'(in_addr - AW'(rpf_pkg::REG_ENTRIES)) : '0;

    rpf_store #(
        .DEPTH (MEM_D),
        .IDX_W (MEM_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en && s1_fire),
        .i_wr_idx  (wr_idx),
        .i_wr_data (wr_data),
        .i_rd_en   (accept),
        .i_rd_idx  (rd_idx),
        .o_rd_data (mem_byte)
    );

    assign s1_addr = (r_cmd == rpf_pkg::CMD_READ) ? AW'(r_idx) : AW'(r_fill);
    assign slen    = (r_b2 > 8'(MAX_DATA)) ? 8'(MAX_DATA) : r_b2;

    always_comb begin
        if (s1_addr >= AW'(STORE)) begin
            s1_byte = 8'h00;
        end else if (s1_addr == AW'(0)) begin
            s1_byte = r_b0;
        end else if (s1_addr == AW'(1)) begin
            s1_byte = r_b1;
        end else if (s1_addr == AW'(2)) begin
            s1_byte = r_b2;
        end else begin
            s1_byte = mem_byte;
        end
    end

    always_comb begin
        logic [FILL_W-1:0] f;
        logic [7:0]        lc;
        n_phase = r_phase;
        n_fill  = r_fill;
        n_crc   = r_crc;
        n_b0    = r_b0;
        n_b1    = r_b1;
        n_b2    = r_b2;
        wr_en   = 1'b0;
        wr_idx  = '0;
        wr_data = r_db;
        n_res   = '0;
        f       = r_fill;
        lc      = r_len_in;
        if (r_cmd <= rpf_pkg::CMD_SENT && r_phase == rpf_pkg::PH_IDLE) begin
            n_fill  = '0;
            n_b2    = 8'h00;
            n_crc   = rpf_pkg::crc_byte(rpf_pkg::CRC_SEED, i_group_id);
            n_phase = rpf_pkg::PH_RECV;
        end else if (r_cmd == rpf_pkg::CMD_RX_BYTE && r_phase == rpf_pkg::PH_RECV) begin
            if (f == '0) begin
                n_b0 = i_group_id;
                f    = FILL_W'(1);
            end
            if (f < FILL_W'(STORE)) begin
                if (f == FILL_W'(1)) begin
                    n_b1 = r_db;
                end else if (f == FILL_W'(2)) begin
                    n_b2 = r_db;
                end else begin
                    wr_en  = 1'b1;
                    wr_idx = MEM_W'(f - FILL_W'(rpf_pkg::REG_ENTRIES));
                end
                f = f + FILL_W'(1);
            end
            n_crc  = rpf_pkg::crc_byte(r_crc, r_db);
            n_fill = f;
            if (9'(f) >= 9'(n_b2) + rpf_pkg::HDR_OVERHEAD || 9'(f) >= 9'(STORE)) begin
                n_phase = rpf_pkg::PH_IDLE;
                if (n_b2 > 8'(MAX_DATA)) begin
                    n_crc = 16'h0001;
                end
                if (!n_b1[6] || i_node_id == rpf_pkg::BCAST_NODE || n_b1[4:0] == i_node_id) begin
                    n_res.packet_ready = 1'b1;
                end
            end
        end else if (r_cmd == rpf_pkg::CMD_SENT && r_phase == rpf_pkg::PH_DONE) begin
            n_phase = rpf_pkg::PH_IDLE;
        end else if ((r_cmd == rpf_pkg::CMD_TX_SPACE || r_cmd == rpf_pkg::CMD_SENT) &&
                     r_phase >= rpf_pkg::PH_DATA && r_phase <= rpf_pkg::PH_TAIL) begin
            n_res.tx_valid = 1'b1;
            case (r_phase)
                rpf_pkg::PH_DATA: begin
                    n_crc         = rpf_pkg::crc_byte(r_crc, s1_byte);
                    n_res.tx_byte = s1_byte;
                    n_fill        = r_fill + FILL_W'(1);
                    if (9'(n_fill) > 9'(slen) + 9'd2) begin
                        n_phase = rpf_pkg::PH_CRC1;
                    end
                end
                rpf_pkg::PH_CRC1: begin
                    n_res.tx_byte = r_crc[7:0];
                    n_phase       = rpf_pkg::PH_CRC2;
                end
                rpf_pkg::PH_CRC2: begin
                    n_res.tx_byte = r_crc[15:8];
                    n_phase       = rpf_pkg::PH_TAIL;
                end
                default: begin
                    n_res.tx_byte = rpf_pkg::TAIL_BYTE;
                    n_phase       = rpf_pkg::PH_DONE;
                end
            endcase
        end else begin
            case (r_cmd)
                rpf_pkg::CMD_LOAD: begin
                    if (AW'(r_idx) < AW'(STORE)) begin
                        if (r_idx == 7'd0) begin
                            n_b0 = r_db;
                        end else if (r_idx == 7'd1) begin
                            n_b1 = r_db;
                        end else if (r_idx == 7'd2) begin
                            n_b2 = r_db;
                        end else begin
                            wr_en  = 1'b1;
                            wr_idx = MEM_W'(AW'(r_idx) - AW'(rpf_pkg::REG_ENTRIES));
                        end
                    end
                end
                rpf_pkg::CMD_START: begin
                    if (lc > 8'(MAX_DATA)) begin
                        lc = 8'(MAX_DATA);
                    end
                    n_b2    = lc;
                    n_b1    = r_hdr_in[6] ? r_hdr_in : {r_hdr_in[7:5], i_node_id};
                    n_crc   = rpf_pkg::crc_byte(rpf_pkg::CRC_SEED, i_group_id);
                    n_fill  = FILL_W'(1);
                    n_phase = rpf_pkg::PH_DATA;
                end
                rpf_pkg::CMD_CAN_SEND: begin
                    if (r_phase == rpf_pkg::PH_RECV && r_fill == '0) begin
                        n_phase        = rpf_pkg::PH_IDLE;
                        n_res.can_send = 1'b1;
                    end
                end
                rpf_pkg::CMD_READ: begin
                    n_res.read_byte = s1_byte;
                end
                default: begin
                end
            endcase
        end
        case (n_phase)
            rpf_pkg::PH_IDLE: n_res.radio_mode = rpf_pkg::MODE_STANDBY;
            rpf_pkg::PH_RECV: n_res.radio_mode = rpf_pkg::MODE_RECEIVER;
            default:          n_res.radio_mode = rpf_pkg::MODE_TRANSMIT;
        endcase
        n_res.crc_good     = (n_crc == 16'h0000);
        n_res.transmitting = (n_phase >= rpf_pkg::PH_DATA);
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd    <= i_s_tuser;
            r_db     <= i_s_tdata[7:0];
            r_hdr_in <= i_s_tdata[15:8];
            r_len_in <= i_s_tdata[23:16];
            r_idx    <= i_s_tdata[30:24];
        end
        if (s1_fire) begin
            r_odata <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1v    <= 1'b0;
            r_ovalid <= 1'b0;
            r_phase  <= rpf_pkg::PH_IDLE;
            r_fill   <= '0;
            r_crc    <= 16'h0000;
            r_b0     <= 8'h00;
            r_b1     <= 8'h00;
            r_b2     <= 8'h00;
        end else begin
            if (accept) begin
                r_s1v <= 1'b1;
            end else if (s1_fire) begin
                r_s1v <= 1'b0;
            end
            if (s1_fire) begin
                r_ovalid <= 1'b1;
                r_phase  <= n_phase;
                r_fill   <= n_fill;
                r_crc    <= n_crc;
                r_b0     <= n_b0;
                r_b1     <= n_b1;
                r_b2     <= n_b2;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_result = r_odata;

`ifndef NO_ASSERTIONS
    a_fire_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire |=> r_ovalid)
        else $error("s1 item lost on its way to the output register");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(STORE))
        else $error("fill count beyond store size");
    a_tx_in_transmit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_odata.tx_valid |-> r_odata.transmitting)
        else $error("radio byte outside a transmit phase");
    a_can_send_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_odata.can_send |-> r_odata.radio_mode == rpf_pkg::MODE_STANDBY)
        else $error("can-send without return to standby");
`endif

endmodule

>>> hw/rtl/radio_packet_framer_top.sv
// top level of the radio packet framer: register port and stream channels
// Each command transfer yields exactly one result transfer. A new command is taken every cycle
// while results are taken. A command is held in the s1 register while the registered read of
// the packet store that starts with its transfer completes; its result is then loaded into the
// output register once that register is free, and the result transfer is made from there. A
// result left waiting holds the input after one more command. Store entries 0..2 are
// flip-flops, the rest a memory with one read and one write port whose valid bits are cleared
// by reset, so no clearing pass follows reset. Registers are to be written only while no
// command is in flight; the user must keep to this, the block itself does not enforce it.
module radio_packet_framer_top #(
    parameter int MAX_DATA = 66
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // data_byte[7:0], header[15:8], length[23:16], index[30:24], zero[31]
    input  logic [31:0] s_axis_tdata,
    // command[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // radio_mode[1:0], tx_valid[2], tx_byte[10:3], packet_ready[11], crc_good[12],
    // can_send[13], read_byte[21:14], transmitting[22], zero[23]
    output logic [23:0] m_axis_tdata
);

    logic [4:0]       r_node_id;
    logic [7:0]       r_group_id;
    logic             cfg_wr;
    rpf_pkg::t_result result;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_id  <= rpf_pkg::NODE_RESET;
            r_group_id <= rpf_pkg::GROUP_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                rpf_pkg::REG_NODE_ID:  r_node_id  <= pwdata[4:0];
                rpf_pkg::REG_GROUP_ID: r_group_id <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            rpf_pkg::REG_NODE_ID:  prdata = {27'd0, r_node_id};
            rpf_pkg::REG_GROUP_ID: prdata = {24'd0, r_group_id};
            default:               prdata = 32'd0;
        endcase
    end

    rpf_core #(
        .MAX_DATA (MAX_DATA)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_node_id  (r_node_id),
        .i_group_id (r_group_id),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_result (result)
    );

    assign m_axis_tdata = result;

endmodule

>>> tb/sv/rpf_frame_checker.sv
// scoreboard for the radio packet framer: frame-level prediction and per-field comparison
`timescale 1ns / 100ps

package rpf_crc_tb_pkg;
    import rpf_pkg::*;

    function automatic logic [15:0] crc16_fold(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] v;
        v = acc ^ {8'h00, b};
        repeat (8) begin
            v = {1'b0, v[15:1]} ^ (v[0] ? CRC_POLY : 16'h0000);
        end
        return v;
    endfunction
endpackage

module rpf_frame_checker #(
    parameter int MAX_DATA = 66
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    // data_byte[7:0], header[15:8], length[23:16], index[30:24], zero[31]
    input  logic [31:0] s_axis_tdata,
    // command[2:0]
    input  logic [2:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // radio_mode[1:0], tx_valid[2], tx_byte[10:3], packet_ready[11], crc_good[12],
    // can_send[13], read_byte[21:14], transmitting[22], zero[23]
    input  logic [23:0] m_axis_tdata,
    output int          o_errors,
    output int          o_pending,
    output int          o_checked,
    output int          o_ready_pkts,
    output int          o_good_pkts,
    output int          o_tx_bytes
);
    import rpf_pkg::*;
    import rpf_crc_tb_pkg::*;

    localparam int STORE_LEN  = MAX_DATA + int'(HDR_OVERHEAD);

    logic [2:0]  link_phase;
    int          fill_pos;
    logic [15:0] crc_acc;
    logic [7:0]  frame_buf [STORE_LEN];
    logic [4:0]  node_reg;
    logic [7:0]  group_reg;
    t_result     due_results [$];

    function automatic t_result framer_result(input logic [2:0] cmd, input logic [7:0] db,
                                              input logic [7:0] hdr, input logic [7:0] len,
                                              input logic [6:0] idx);
        t_result    r;
        logic [7:0] hb;
        logic [7:0] b;
        logic [7:0] send_len;
        r = '0;
        if (cmd <= CMD_SENT && link_phase == PH_IDLE) begin
            fill_pos = 0;
            frame_buf[2] = 8'h00;
            crc_acc = crc16_fold(CRC_SEED, group_reg);
            link_phase = PH_RECV;
        end else if (cmd == CMD_RX_BYTE && link_phase == PH_RECV) begin
            if (fill_pos == 0) begin
                frame_buf[0] = group_reg;
                fill_pos = 1;
            end
            if (fill_pos < STORE_LEN) begin
                frame_buf[fill_pos] = db;
                fill_pos++;
            end
            crc_acc = crc16_fold(crc_acc, db);
            if (fill_pos >= int'(frame_buf[2]) + int'(HDR_OVERHEAD) || fill_pos >= STORE_LEN) begin
                hb = frame_buf[1];
                link_phase = PH_IDLE;
                // oversized length field spoils the crc on purpose
                if (frame_buf[2] > MAX_DATA) crc_acc = 16'h0001;
                if (!hb[6] || node_reg == BCAST_NODE || hb[4:0] == node_reg) r.packet_ready = 1'b1;
            end
        end else if (cmd == CMD_SENT && link_phase == PH_DONE) begin
            link_phase = PH_IDLE;
        end else if ((cmd == CMD_TX_SPACE || cmd == CMD_SENT) &&
                     link_phase >= PH_DATA && link_phase <= PH_TAIL) begin
            r.tx_valid = 1'b1;
            case (link_phase)
                PH_DATA: begin
                    b = fill_pos < STORE_LEN ? frame_buf[fill_pos] : 8'h00;
                    crc_acc = crc16_fold(crc_acc, b);
                    r.tx_byte = b;
                    fill_pos++;
                    // length byte re-read each time, it may have been overwritten
                    send_len = frame_buf[2] > MAX_DATA ? 8'(MAX_DATA) : frame_buf[2];
                    if (fill_pos > int'(send_len) + 2) link_phase = PH_CRC1;
                end
                PH_CRC1: begin
                    r.tx_byte = crc_acc[7:0];
                    link_phase = PH_CRC2;
                end
                PH_CRC2: begin
                    r.tx_byte = crc_acc[15:8];
                    link_phase = PH_TAIL;
                end
                default: begin
                    r.tx_byte = TAIL_BYTE;
                    link_phase = PH_DONE;
                end
            endcase
        end else if (cmd == CMD_LOAD) begin
            if (idx < STORE_LEN) frame_buf[idx] = db;
        end else if (cmd == CMD_START) begin
            frame_buf[2] = len > MAX_DATA ? 8'(MAX_DATA) : len;
            frame_buf[1] = hdr[6] ? hdr : {hdr[7:5], node_reg};
            crc_acc = crc16_fold(CRC_SEED, group_reg);
            fill_pos = 1;
            link_phase = PH_DATA;
        end else if (cmd == CMD_CAN_SEND) begin
            if (link_phase == PH_RECV && fill_pos == 0) begin
                link_phase = PH_IDLE;
                r.can_send = 1'b1;
            end
        end else if (cmd == CMD_READ) begin
            if (idx < STORE_LEN) r.read_byte = frame_buf[idx];
        end
        r.radio_mode = link_phase == PH_IDLE ? MODE_STANDBY :
                       link_phase == PH_RECV ? MODE_RECEIVER : MODE_TRANSMIT;
        r.crc_good = crc_acc == 16'h0000;
        r.transmitting = link_phase >= PH_DATA;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            o_errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            link_phase = PH_IDLE;
            fill_pos = 0;
            crc_acc = 16'h0000;
            frame_buf = '{default: 8'h00};
            node_reg = NODE_RESET;
            group_reg = GROUP_RESET;
            due_results.delete();
            o_errors = 0;
            o_checked = 0;
            o_ready_pkts = 0;
            o_good_pkts = 0;
            o_tx_bytes = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_NODE_ID) node_reg = pwdata[4:0];
                else group_reg = pwdata[7:0];
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_result'(m_axis_tdata);
                if (due_results.size() == 0) begin
                    o_errors++;
                    $display("%0t: result transfer with nothing outstanding, got %h",
                             $time, m_axis_tdata);
                end else begin
                    want = due_results.pop_front();
                    check_field("radio_mode", want.radio_mode, got.radio_mode);
                    check_field("tx_valid", want.tx_valid, got.tx_valid);
                    check_field("tx_byte", want.tx_byte, got.tx_byte);
                    check_field("packet_ready", want.packet_ready, got.packet_ready);
                    check_field("crc_good", want.crc_good, got.crc_good);
                    check_field("can_send", want.can_send, got.can_send);
                    check_field("read_byte", want.read_byte, got.read_byte);
                    check_field("transmitting", want.transmitting, got.transmitting);
                    check_field("pad", want.pad, got.pad);
                    o_checked++;
                    if (want.packet_ready) o_ready_pkts++;
                    if (want.packet_ready && want.crc_good) o_good_pkts++;
                    if (want.tx_valid) o_tx_bytes++;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                due_results.push_back(framer_result(s_axis_tuser, s_axis_tdata[7:0],
                                                    s_axis_tdata[15:8], s_axis_tdata[23:16],
                                                    s_axis_tdata[30:24]));
        end
        o_pending <= due_results.size();
    end

endmodule

>>> tb/sv/tb_radio_packet_framer_top.sv
// stimulus, clocking and verdict for the radio packet framer testbench
`timescale 1ns / 100ps

module tb_radio_packet_framer_top;
    import rpf_pkg::*;
    import rpf_crc_tb_pkg::*;

    localparam int MAX_DATA   = 66;
    localparam int CLK_PERIOD = 20;
    localparam int N_PHASES   = 6;
    localparam int ITEMS      = 1500;
    // worst quiet stretch is a sender gap plus a receiver stall plus latency, far below this
    localparam int QUIET_LIMIT = 2000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = CMD_LISTEN;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [23:0] m_axis_tdata;

    int fail_count;
    int pending_count;
    int checked_count;
    int ready_count;
    int good_count;
    int tx_count;

    int         items_sent = 0;
    int         n_settings = 0;
    int         quiet_cycles = 0;
    int         hold_left = 0;
    bit         idle_on = 1'b1;
    bit         sync_idle = 1'b1;
    logic [4:0] cur_node = NODE_RESET;
    logic [7:0] cur_group = GROUP_RESET;
    logic [2:0] wake_cmds [4] = '{CMD_LISTEN, CMD_RX_BYTE, CMD_TX_SPACE, CMD_SENT};

    radio_packet_framer_top #(.MAX_DATA(MAX_DATA)) DUT (.*);

    rpf_frame_checker #(.MAX_DATA(MAX_DATA)) u_checker (
        .*,
        .o_errors     (fail_count),
        .o_pending    (pending_count),
        .o_checked    (checked_count),
        .o_ready_pkts (ready_count),
        .o_good_pkts  (good_count),
        .o_tx_bytes   (tx_count)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // result side back-pressure in bursts
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready = 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            hold_left = $urandom_range(1, 8) - 1;
            m_axis_tready = 1'b0;
        end else begin
            m_axis_tready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, giving up", $time, QUIET_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [7:0] any_byte();
        return 8'($urandom);
    endfunction

    function automatic logic [6:0] any_idx();
        return 7'($urandom);
    endfunction

    function automatic logic [7:0] pick_len(input bit rx_side);
        case ($urandom_range(0, 9))
            0: return 8'($urandom_range(0, MAX_DATA));
            1: return rx_side ? 8'($urandom_range(MAX_DATA + 1, 255)) : any_byte();
            default: return 8'($urandom_range(0, 8));
        endcase
    endfunction

    task automatic wait_drained();
        while (pending_count != 0) @(negedge i_clk);
    endtask

    task automatic reg_write(input logic reg_sel, input logic [31:0] value);
        @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {reg_sel, 2'b00};
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic push_cmd(input logic [2:0] cmd, input logic [7:0] db, input logic [7:0] hdr,
                            input logic [7:0] len, input logic [6:0] idx);
        if (idle_on && $urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        s_axis_tuser = cmd;
        s_axis_tdata = {1'b0, idx, len, hdr, db};
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        items_sent++;
    endtask

    // zero-length send run to the end brings the framer back to idle from anywhere
    task automatic flush_link();
        push_cmd(CMD_START, any_byte(), any_byte(), 8'h00, any_idx());
        repeat (6) push_cmd(CMD_SENT, any_byte(), any_byte(), any_byte(), any_idx());
        sync_idle = 1'b1;
    endtask

    task automatic rx_frame(input logic [7:0] hdr, input logic [7:0] len, input bit corrupt);
        logic [7:0]  body [$];
        logic [15:0] acc;
        int          pos;
        if (!sync_idle) flush_link();
        body.push_back(hdr);
        body.push_back(len);
        if (len <= MAX_DATA) begin
            repeat (len) body.push_back(any_byte());
            acc = crc16_fold(CRC_SEED, cur_group);
            foreach (body[i]) acc = crc16_fold(acc, body[i]);
            body.push_back(acc[7:0]);
            body.push_back(acc[15:8]);
            if (corrupt) begin
                pos = $urandom_range(2, body.size() - 1);
                body[pos] = body[pos] ^ (8'h01 << $urandom_range(0, 7));
            end
        end else begin
            // runs until the store is full
            repeat (MAX_DATA + 2) body.push_back(any_byte());
        end
        push_cmd(wake_cmds[$urandom_range(0, 3)], any_byte(), any_byte(), any_byte(), any_idx());
        foreach (body[i]) begin
            if ($urandom_range(0, 7) == 0)
                push_cmd($urandom_range(0, 1) ? CMD_READ : CMD_LISTEN, any_byte(), any_byte(),
                         any_byte(), any_idx());
            push_cmd(CMD_RX_BYTE, body[i], any_byte(), any_byte(), any_idx());
        end
        repeat ($urandom_range(0, 3))
            push_cmd(CMD_READ, any_byte(), any_byte(), any_byte(),
                     $urandom_range(0, 1) ? any_idx() : 7'($urandom_range(0, MAX_DATA + 4)));
        sync_idle = 1'b1;
    endtask

    task automatic tx_frame(input logic [7:0] hdr, input logic [7:0] len);
        int eff;
        bit alter;
        repeat ($urandom_range(0, 4))
            push_cmd(CMD_LOAD, any_byte(), any_byte(), any_byte(),
                     7'($urandom_range(0, MAX_DATA + 9)));
        push_cmd(CMD_START, any_byte(), hdr, len, any_idx());
        eff = len > MAX_DATA ? MAX_DATA : int'(len);
        alter = $urandom_range(0, 9) == 0;
        for (int n = 0; n < eff + 5; n++) begin
            if ($urandom_range(0, 9) == 0)
                push_cmd(CMD_READ, any_byte(), any_byte(), any_byte(), any_idx());
            // length byte overwritten while the payload goes out
            if (alter && n == eff / 2)
                push_cmd(CMD_LOAD, any_byte(), any_byte(), any_byte(), 7'd2);
            push_cmd($urandom_range(0, 3) == 0 ? CMD_SENT : CMD_TX_SPACE, any_byte(), any_byte(),
                     any_byte(), any_idx());
        end
        if (!alter && $urandom_range(0, 3) == 0)
            push_cmd(CMD_TX_SPACE, any_byte(), any_byte(), any_byte(), any_idx());
        push_cmd(CMD_SENT, any_byte(), any_byte(), any_byte(), any_idx());
        sync_idle = !alter;
    endtask

    initial begin
        logic [4:0] nd;
        logic [7:0] gp;
        logic [7:0] hdr;
        int         phase_end;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        push_cmd(CMD_READ, 8'h00, 8'h00, 8'h00, 7'd0);
        push_cmd(CMD_CAN_SEND, 8'h00, 8'h00, 8'h00, 7'd0);
        push_cmd(CMD_LISTEN, 8'h00, 8'h00, 8'h00, 7'd0);
        push_cmd(CMD_CAN_SEND, 8'h00, 8'h00, 8'h00, 7'd0);
        push_cmd(CMD_LOAD, 8'h00, 8'h00, 8'h00, 7'd127);
        push_cmd(CMD_LOAD, 8'hFF, 8'hFF, 8'hFF, 7'd70);
        push_cmd(CMD_READ, 8'hFF, 8'hFF, 8'hFF, 7'd70);
        push_cmd(CMD_READ, 8'h00, 8'h00, 8'h00, 7'd71);
        rx_frame({3'b010, cur_node}, 8'd2, 1'b0);
        push_cmd(CMD_START, 8'h00, 8'hBF, 8'h00, 7'd0);
        push_cmd(CMD_TX_SPACE, 8'h00, 8'h00, 8'h00, 7'd0);
        push_cmd(CMD_LOAD, 8'h01, 8'h00, 8'h00, 7'd2);
        push_cmd(CMD_SENT, 8'h00, 8'h00, 8'h00, 7'd0);
        push_cmd(CMD_TX_SPACE, 8'h00, 8'h00, 8'h00, 7'd0);
        push_cmd(CMD_TX_SPACE, 8'h00, 8'h00, 8'h00, 7'd0);
        push_cmd(CMD_SENT, 8'h00, 8'h00, 8'h00, 7'd0);
        push_cmd(CMD_TX_SPACE, 8'h00, 8'h00, 8'h00, 7'd0);
        push_cmd(CMD_TX_SPACE, 8'h00, 8'h00, 8'h00, 7'd0);
        push_cmd(CMD_SENT, 8'h00, 8'h00, 8'h00, 7'd0);
        push_cmd(CMD_START, 8'hFF, 8'hFF, 8'hFF, 7'd127);
        flush_link();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin
                    nd = BCAST_NODE;
                    gp = 8'h00;
                end
                1: begin
                    nd = 5'd0;
                    gp = 8'hFF;
                end
                default: begin
                    nd = 5'($urandom);
                    gp = any_byte();
                end
            endcase
            wait_drained();
            reg_write(REG_NODE_ID, {27'd0, nd});
            reg_write(REG_GROUP_ID, {24'd0, gp});
            cur_node = nd;
            cur_group = gp;
            n_settings++;
            if (ph == 0) rx_frame(any_byte(), 8'hFF, 1'b0);
            phase_end = items_sent + ITEMS / N_PHASES;
            while (items_sent < phase_end) begin
                idle_on = ph != N_PHASES - 1 && $urandom_range(0, 4) != 0;
                case ($urandom_range(0, 9))
                    0, 1: begin
                        repeat ($urandom_range(1, 6))
                            push_cmd(3'($urandom), any_byte(), any_byte(), any_byte(), any_idx());
                        sync_idle = 1'b0;
                    end
                    2, 3, 4, 5: begin
                        hdr = any_byte();
                        case ($urandom_range(0, 3))
                            0: hdr[6] = 1'b0;
                            1: hdr = {hdr[7], 1'b1, hdr[5], cur_node};
                            default: ;
                        endcase
                        rx_frame(hdr, pick_len(1'b1), $urandom_range(0, 3) == 0);
                    end
                    default: tx_frame(any_byte(), pick_len(1'b0));
                endcase
            end
        end

        wait_drained();
        repeat (8) @(negedge i_clk);
        $display("Covered %0d commands and %0d checked results under %0d register settings",
                 items_sent, checked_count, n_settings + 1);
        $display("%0d packets accepted (%0d with intact crc), %0d bytes framed for the radio",
                 ready_count, good_count, tx_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> radio_packet_framer_top.f
hw/rtl/rpf_pkg.sv
hw/rtl/rpf_store.sv
hw/rtl/rpf_core.sv
hw/rtl/radio_packet_framer_top.sv
tb/sv/rpf_frame_checker.sv
tb/sv/tb_radio_packet_framer_top.sv
